// ===== sv/lfcm_pkg.sv =====
// Package for the luminance false-colour map.
// Holds the shared constants, the register index codes and the control struct.
// No dependencies.
package lfcm_pkg;

  localparam int LevelBitsDef = 16;
  localparam int OutDataW     = 24;

  localparam logic [15:0] LowLevelRst  = 16'h0000;
  localparam logic [15:0] HighLevelRst = 16'hFFFF;

  localparam logic [7:0] ChanFull      = 8'd255;
  localparam logic [7:0] ChanZero      = 8'd0;
  localparam logic [7:0] ZeroBandGreen = 8'd100;

  typedef enum logic [0:0] {
    REG_LOW  = 1'b0,
    REG_HIGH = 1'b1
  } cfg_reg_e;

  // Control carried alongside the arithmetic of one sample.
  typedef struct packed {
    logic       fix;     // colour is a fixed value, the arithmetic is ignored
    logic       second;  // sample lies in the upper quarter of the band
    logic [7:0] fix_r;
    logic [7:0] fix_g;
    logic [7:0] fix_b;
  } ctl_t;

endpackage

// ===== sv/lfcm_prep.sv =====
// First pipeline stage of the luminance false-colour map: band classification,
// quarter width, offsets from the parabola centres and the green factors.
// Depends on lfcm_pkg.
module lfcm_prep #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [LEVEL_BITS-1:0]   lum_i,
  input  logic [LEVEL_BITS-1:0]   low_i,
  input  logic [LEVEL_BITS-1:0]   high_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output lfcm_pkg::ctl_t          ctl_o,
  output logic [LEVEL_BITS-3:0]   a_o,
  output logic [2:0][LEVEL_BITS-1:0] t_o,
  output logic signed [LEVEL_BITS+2:0] p_o,
  output logic signed [LEVEL_BITS+1:0] s_o
);
  import lfcm_pkg::*;

  localparam int L = LEVEL_BITS;

  logic                 above, below, zero_band, narrow, first;
  logic [L-1:0]         width, d, a3, a2, cb;
  logic [L-3:0]         a;
  logic [L+1:0]         a9;
  logic [2:0][L-1:0]    t_d;
  ctl_t                 ctl_d;
  logic signed [L+2:0]  p_d;
  logic signed [L+1:0]  s_d;

  logic                 valid_q;
  ctl_t                 ctl_q;
  logic [L-3:0]         a_q;
  logic [2:0][L-1:0]    t_q;
  logic signed [L+2:0]  p_q;
  logic signed [L+1:0]  s_q;

  always_comb begin
    above     = lum_i > high_i;
    below     = lum_i < low_i;
    zero_band = low_i == high_i;
    width     = high_i - low_i;
    a         = width[L-1:2];
    narrow    = a == '0;
    d         = lum_i - low_i;
    a2        = {1'b0, a, 1'b0};
    a3        = {2'b00, a} + a2;
    first     = d < a3;
    cb        = first ? {2'b00, a} : {a, 2'b00};

    t_d[0] = (d >= a3) ? d - a3 : a3 - d;
    t_d[1] = (d >= a2) ? d - a2 : a2 - d;
    t_d[2] = (d >= cb) ? d - cb : cb - d;

    a9  = {a, 3'b000} + {4'b0000, a};
    p_d = $signed({2'b00, d, 1'b0}) - $signed({1'b0, a9});
    s_d = $signed({2'b00, d}) - $signed({2'b00, a, 2'b00});

    ctl_d.second = ~first;
    ctl_d.fix    = 1'b1;
    ctl_d.fix_r  = ChanZero;
    ctl_d.fix_g  = ChanZero;
    ctl_d.fix_b  = ChanZero;
    if (above) begin
      ctl_d.fix_r = ChanFull;
      ctl_d.fix_g = ChanFull;
      ctl_d.fix_b = ChanFull;
    end else if (below) begin
      ctl_d.fix_r = ChanZero;
    end else if (zero_band) begin
      ctl_d.fix_g = ZeroBandGreen;
    end else if (narrow) begin
      ctl_d.fix_r = ChanFull;
    end else begin
      ctl_d.fix = 1'b0;
    end
  end

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ctl_q <= ctl_d;
      a_q   <= a;
      t_q   <= t_d;
      p_q   <= p_d;
      s_q   <= s_d;
    end
  end

  assign out_valid_o = valid_q;
  assign ctl_o       = ctl_q;
  assign a_o         = a_q;
  assign t_o         = t_q;
  assign p_o         = p_q;
  assign s_o         = s_q;

endmodule

// ===== sv/lfcm_mult.sv =====
// Second pipeline stage of the luminance false-colour map: the squares of the
// quarter width and of the three offsets, and the green product.
// Depends on lfcm_pkg.
module lfcm_mult #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lfcm_pkg::ctl_t               ctl_i,
  input  logic [LEVEL_BITS-3:0]        a_i,
  input  logic [2:0][LEVEL_BITS-1:0]   t_i,
  input  logic signed [LEVEL_BITS+2:0] p_i,
  input  logic signed [LEVEL_BITS+1:0] s_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lfcm_pkg::ctl_t               ctl_o,
  output logic [2*LEVEL_BITS-5:0]      asq_o,
  output logic [2:0][2*LEVEL_BITS-1:0] sq_o,
  output logic signed [2*LEVEL_BITS+4:0] prod_o
);
  import lfcm_pkg::*;

  localparam int L = LEVEL_BITS;

  logic                    valid_q;
  ctl_t                    ctl_q;
  logic [2*L-5:0]          asq_q;
  logic [2:0][2*L-1:0]     sq_q;
  logic signed [2*L+4:0]   prod_q;

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ctl_q  <= ctl_i;
      asq_q  <= a_i * a_i;
      sq_q[0] <= t_i[0] * t_i[0];
      sq_q[1] <= t_i[1] * t_i[1];
      sq_q[2] <= t_i[2] * t_i[2];
      prod_q <= p_i * s_i;
    end
  end

  assign out_valid_o = valid_q;
  assign ctl_o       = ctl_q;
  assign asq_o       = asq_q;
  assign sq_o        = sq_q;
  assign prod_o      = prod_q;

endmodule

// ===== sv/lfcm_rem.sv =====
// Third pipeline stage of the luminance false-colour map: sets up the dividend
// 255*(den - num) and the divisor of each channel for the quotient stages.
// Depends on lfcm_pkg.
module lfcm_rem #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lfcm_pkg::ctl_t                 ctl_i,
  input  logic [2*LEVEL_BITS-5:0]        asq_i,
  input  logic [2:0][2*LEVEL_BITS-1:0]   sq_i,
  input  logic signed [2*LEVEL_BITS+4:0] prod_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0][2*LEVEL_BITS+4:0]   rem_o,
  output logic [2*LEVEL_BITS-4:0]        den_p_o,
  output logic [2*LEVEL_BITS-4:0]        den_g_o
);
  import lfcm_pkg::*;

  localparam int L  = LEVEL_BITS;
  localparam int SW = 2 * L;
  localparam int DW = 2 * L - 3;
  localparam int RW = DW + 8;
  localparam int PW = 2 * L + 5;

  // 255 * x as a shift and a subtraction.
  function automatic logic [RW-1:0] mul255(input logic [DW-1:0] x);
    return {x, 8'h00} - {8'h00, x};
  endfunction

  logic [2:0][DW-1:0] x;
  logic [2:0][RW-1:0] rem_d;
  logic [DW-1:0]      den_p_d, den_g_d, den_g2, x_g2;
  logic               prod_pos, prod_lt;

  logic               valid_q;
  logic [2:0][RW-1:0] rem_q;
  logic [DW-1:0]      den_p_q, den_g_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (sq_i[c] < {4'b0000, asq_i}) begin
        x[c] = {1'b0, asq_i - sq_i[c][SW-5:0]};
      end else begin
        x[c] = '0;
      end
    end

    den_g2   = {asq_i, 1'b0};
    prod_pos = prod_i > 0;
    prod_lt  = prod_i < $signed({{(PW-DW){1'b0}}, den_g2});
    x_g2     = prod_lt ? den_g2 - prod_i[DW-1:0] : '0;

    den_p_d  = {1'b0, asq_i};
    den_g_d  = den_p_d;
    rem_d[0] = mul255(x[0]);
    rem_d[1] = mul255(x[1]);
    rem_d[2] = mul255(x[2]);

    if (ctl_i.fix) begin
      // A divisor of one passes the fixed colour straight through.
      den_p_d  = DW'(1);
      den_g_d  = DW'(1);
      rem_d[0] = {{(RW-8){1'b0}}, ctl_i.fix_r};
      rem_d[1] = {{(RW-8){1'b0}}, ctl_i.fix_g};
      rem_d[2] = {{(RW-8){1'b0}}, ctl_i.fix_b};
    end else if (ctl_i.second) begin
      // Red is full, and a dividend of 255 times the divisor yields exactly 255.
      rem_d[0] = mul255(den_p_d);
      den_g_d  = den_g2;
      rem_d[1] = prod_pos ? mul255(x_g2) : mul255(den_g2);
    end
  end

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rem_q   <= rem_d;
      den_p_q <= den_p_d;
      den_g_q <= den_g_d;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign den_p_o     = den_p_q;
  assign den_g_o     = den_g_q;

  // Every quotient must fit in eight bits.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rem_q[0] < (RW'(den_p_q) << 8)) && (rem_q[1] < (RW'(den_g_q) << 8)) &&
                (rem_q[2] < (RW'(den_p_q) << 8)))
    else $error("lfcm_rem: dividend too large for an eight bit quotient");

endmodule

// ===== sv/lfcm_div_step.sv =====
// One restoring division stage of the luminance false-colour map: settles one
// quotient bit of each of the three channels.
// Depends on lfcm_pkg.
module lfcm_div_step #(
  parameter int LEVEL_BITS = 16,
  parameter int STEP       = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0][2*LEVEL_BITS+4:0] rem_i,
  input  logic [2*LEVEL_BITS-4:0]      den_p_i,
  input  logic [2*LEVEL_BITS-4:0]      den_g_i,
  input  logic [2:0][7:0]              q_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0][2*LEVEL_BITS+4:0] rem_o,
  output logic [2*LEVEL_BITS-4:0]      den_p_o,
  output logic [2*LEVEL_BITS-4:0]      den_g_o,
  output logic [2:0][7:0]              q_o
);
  import lfcm_pkg::*;

  localparam int DW = 2 * LEVEL_BITS - 3;
  localparam int RW = DW + 8;

  logic [2:0][RW-1:0] dsh;
  logic [2:0][RW-1:0] rem_d;
  logic [2:0][7:0]    q_d;

  logic               valid_q;
  logic [2:0][RW-1:0] rem_q;
  logic [DW-1:0]      den_p_q, den_g_q;
  logic [2:0][7:0]    q_q;

  always_comb begin
    dsh[0] = RW'(den_p_i) << STEP;
    dsh[1] = RW'(den_g_i) << STEP;
    dsh[2] = RW'(den_p_i) << STEP;
    for (int c = 0; c < 3; c++) begin
      q_d[c] = q_i[c];
      if (rem_i[c] >= dsh[c]) begin
        rem_d[c]     = rem_i[c] - dsh[c];
        q_d[c][STEP] = 1'b1;
      end else begin
        rem_d[c] = rem_i[c];
      end
    end
  end

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rem_q   <= rem_d;
      den_p_q <= den_p_i;
      den_g_q <= den_g_i;
      q_q     <= q_d;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign den_p_o     = den_p_q;
  assign den_g_o     = den_g_q;
  assign q_o         = q_q;

  // After this stage the remainder is below the divisor shifted by STEP.
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rem_q[0] < (RW'(den_p_q) << STEP)) && (rem_q[1] < (RW'(den_g_q) << STEP)) &&
                (rem_q[2] < (RW'(den_p_q) << STEP)))
    else $error("lfcm_div_step: remainder not reduced");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (den_p_q != '0) && (den_g_q != '0))
    else $error("lfcm_div_step: zero divisor in flight");

endmodule

// ===== sv/luminance_false_color_map.sv =====
// Top level of the luminance false-colour map.
// Instantiates lfcm_prep, lfcm_mult, lfcm_rem and eight lfcm_div_step stages;
// depends on lfcm_pkg.
//
// The block turns a stream of luminance samples into false-colour RGB pixels.
// Samples arrive on the s_axis channel, one per transfer, and each produces
// exactly one pixel on the m_axis channel, in order. Inside the band set by
// the low_level and high_level registers each channel follows an inverted
// parabola; above the band the pixel is white, below it black, a band of zero
// width gives dark green and a band narrower than four gives pure red.
//
// The registers are written through cfg_we_i, cfg_idx_i and cfg_data_i, and
// they should only change while no sample is in flight.
//
// The datapath is an eleven-stage pipeline: classification, the multipliers,
// the dividend set-up and eight restoring division stages, one quotient bit
// each. Every stage is registered, and while m_axis is not stalled a new
// sample can be taken on every cycle, so the sustained rate is one pixel per
// clock. Each stage has its own valid bit and accepts data when it is empty
// or its successor moves, so a stall on m_axis fills up the bubbles first and
// only then drops s_axis_tready; nothing is lost or repeated.
//
// Reset empties the pipeline and sets the band to low 0, high 65535.
module luminance_false_color_map #(
  parameter int LEVEL_BITS = lfcm_pkg::LevelBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Sample input. tdata: luminance in the low LEVEL_BITS bits, zero padded.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((LEVEL_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // Pixel output. tdata: red [7:0], green [15:8], blue [23:16].
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [lfcm_pkg::OutDataW-1:0]        m_axis_tdata,
  // Register write port.
  input  logic                                 cfg_we_i,
  input  lfcm_pkg::cfg_reg_e                   cfg_idx_i,
  input  logic [LEVEL_BITS-1:0]                cfg_data_i
);
  import lfcm_pkg::*;

  localparam int L      = LEVEL_BITS;
  localparam int DW     = 2 * L - 3;
  localparam int RW     = DW + 8;
  localparam int NSteps = 8;

  logic [L-1:0] low_q, high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= L'(LowLevelRst);
      high_q <= L'(HighLevelRst);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW:  low_q  <= cfg_data_i;
        REG_HIGH: high_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Stage 1: classification and offsets.
  logic                     v1, r1;
  ctl_t                     ctl1;
  logic [L-3:0]             a1;
  logic [2:0][L-1:0]        t1;
  logic signed [L+2:0]      p1;
  logic signed [L+1:0]      s1;

  lfcm_prep #(.LEVEL_BITS(L)) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .lum_i       (s_axis_tdata[L-1:0]),
    .low_i       (low_q),
    .high_i      (high_q),
    .out_valid_o (v1),
    .out_ready_i (r1),
    .ctl_o       (ctl1),
    .a_o         (a1),
    .t_o         (t1),
    .p_o         (p1),
    .s_o         (s1)
  );

  // Stage 2: squares and the green product.
  logic                     v2, r2;
  ctl_t                     ctl2;
  logic [2*L-5:0]           asq2;
  logic [2:0][2*L-1:0]      sq2;
  logic signed [2*L+4:0]    prod2;

  lfcm_mult #(.LEVEL_BITS(L)) u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1),
    .in_ready_o  (r1),
    .ctl_i       (ctl1),
    .a_i         (a1),
    .t_i         (t1),
    .p_i         (p1),
    .s_i         (s1),
    .out_valid_o (v2),
    .out_ready_i (r2),
    .ctl_o       (ctl2),
    .asq_o       (asq2),
    .sq_o        (sq2),
    .prod_o      (prod2)
  );

  // Stage 3 feeds the division chain at index 0.
  logic                     dv    [0:NSteps];
  logic                     dr    [0:NSteps];
  logic [2:0][RW-1:0]       drem  [0:NSteps];
  logic [DW-1:0]            dden_p[0:NSteps];
  logic [DW-1:0]            dden_g[0:NSteps];
  logic [2:0][7:0]          dq    [0:NSteps];

  lfcm_rem #(.LEVEL_BITS(L)) u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2),
    .in_ready_o  (r2),
    .ctl_i       (ctl2),
    .asq_i       (asq2),
    .sq_i        (sq2),
    .prod_i      (prod2),
    .out_valid_o (dv[0]),
    .out_ready_i (dr[0]),
    .rem_o       (drem[0]),
    .den_p_o     (dden_p[0]),
    .den_g_o     (dden_g[0])
  );

  assign dq[0] = '0;

  for (genvar k = 0; k < NSteps; k++) begin : g_div
    lfcm_div_step #(.LEVEL_BITS(L), .STEP(NSteps - 1 - k)) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dv[k]),
      .in_ready_o  (dr[k]),
      .rem_i       (drem[k]),
      .den_p_i     (dden_p[k]),
      .den_g_i     (dden_g[k]),
      .q_i         (dq[k]),
      .out_valid_o (dv[k+1]),
      .out_ready_i (dr[k+1]),
      .rem_o       (drem[k+1]),
      .den_p_o     (dden_p[k+1]),
      .den_g_o     (dden_g[k+1]),
      .q_o         (dq[k+1])
    );
  end

  assign dr[NSteps]    = m_axis_tready;
  assign m_axis_tvalid = dv[NSteps];
  assign m_axis_tdata  = {dq[NSteps][2], dq[NSteps][1], dq[NSteps][0]};

  // The input can only be held off when every stage, the last included, is full.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("luminance_false_color_map: input stalled with room in the pipeline");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for luminance_false_color_map: streams samples with
// random gaps and stalls and checks every pixel against a local colour model.
// Depends on lfcm_pkg and the luminance_false_color_map RTL.
module tb;
  import lfcm_pkg::*;

  localparam int LvlW       = LevelBitsDef;
  localparam int SampleW    = ((LvlW + 7) / 8) * 8;
  localparam int PipeDepth  = 11;
  localparam int IdleLimit  = 2000;
  localparam int MaxGap     = 17;

  // One pixel as it travels in m_axis_tdata: red in the lowest byte.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Work for the sample driver: a sample transfer, a register write, or a
  // hold until every pixel already owed has come out.
  typedef enum logic [1:0] {
    ACT_SAMPLE,
    ACT_WRITE,
    ACT_SETTLE
  } act_e;

  typedef struct {
    act_e        act;
    cfg_reg_e    sel;
    logic [15:0] value;
  } job_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [SampleW-1:0] s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic               cfg_we_i = 1'b0;
  cfg_reg_e           cfg_idx_i = REG_LOW;
  logic [LvlW-1:0]    cfg_data_i = '0;

  job_t   job_q[$];     // pending driver work, filled once at the start
  pixel_t pixel_q[$];   // pixels owed by the block, oldest first

  // The band as the driver has programmed it; used to colour each sample.
  logic [15:0] band_lo = LowLevelRst;
  logic [15:0] band_hi = HighLevelRst;
  // The band as the stimulus generator expects it, used only to aim samples.
  logic [15:0] plan_lo = LowLevelRst;
  logic [15:0] plan_hi = HighLevelRst;

  int errors = 0;
  int idle_cycles = 0;
  int tx_wait = 0;
  int tx_calm = 0;
  int rx_wait = 0;
  int rx_calm = 0;

  wire tx_fire = s_axis_tvalid && s_axis_tready;
  wire rx_fire = m_axis_tvalid && m_axis_tready;

  luminance_false_color_map #(
    .LEVEL_BITS(LvlW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // luminance [15:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // red [7:0], green [15:8], blue [23:16]
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Reset is held at the start and never asserted again.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------
  // Colour model
  // ---------------------------------------------------------------------

  // 255 - num/den, with the quotient rounded up so that the channel value is
  // truncated, and clamped at zero.
  function automatic logic [7:0] shade_down(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = (num + den - 1) / den;
    r = (q >= 255) ? 0 : 255 - q;
    return r[7:0];
  endfunction

  // Inverted parabola peaking at full brightness where d meets the centre.
  function automatic logic [7:0] arc_level(longint unsigned d, longint unsigned centre,
                                           longint unsigned a);
    longint unsigned t;
    t = (d >= centre) ? d - centre : centre - d;
    return shade_down(255 * t * t, a * a);
  endfunction

  function automatic pixel_t false_colour(logic [15:0] lum, logic [15:0] lo,
                                          logic [15:0] hi);
    pixel_t          c;
    longint unsigned a;
    longint unsigned d;
    longint          p;
    longint          s;
    longint          prod;
    if (lum > hi) begin
      c.red = ChanFull; c.green = ChanFull; c.blue = ChanFull;
    end else if (lum < lo) begin
      c.red = ChanZero; c.green = ChanZero; c.blue = ChanZero;
    end else if (lo == hi) begin
      c.red = ChanZero; c.green = ZeroBandGreen; c.blue = ChanZero;
    end else begin
      a = (hi - lo) / 4;
      d = lum - lo;
      if (a == 0) begin
        // Band one to three levels wide: too narrow for any gradient.
        c.red = ChanFull; c.green = ChanZero; c.blue = ChanZero;
      end else if (d < 3 * a) begin
        c.red   = arc_level(d, 3 * a, a);
        c.green = arc_level(d, 2 * a, a);
        c.blue  = arc_level(d, a, a);
      end else begin
        // Upper quarter: green follows (d - 4.5a)(d - 4a), kept in whole
        // numbers by doubling both sides, and saturates where it goes negative.
        p    = 2 * longint'(d) - 9 * longint'(a);
        s    = longint'(d) - 4 * longint'(a);
        prod = p * s;
        c.red  = ChanFull;
        c.blue = arc_level(d, 4 * a, a);
        if (prod <= 0) c.green = ChanFull;
        else c.green = shade_down(255 * unsigned'(prod), 2 * a * a);
      end
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic add_sample(logic [15:0] v);
    job_t j;
    j.act = ACT_SAMPLE; j.sel = REG_LOW; j.value = v;
    job_q.push_back(j);
  endtask

  task automatic add_settle();
    job_t j;
    j.act = ACT_SETTLE; j.sel = REG_LOW; j.value = '0;
    job_q.push_back(j);
  endtask

  // Registers only change once the pipeline has drained.
  task automatic add_write(cfg_reg_e sel, logic [15:0] v);
    job_t j;
    j.act = ACT_WRITE; j.sel = sel; j.value = v;
    job_q.push_back(j);
    if (sel == REG_LOW) plan_lo = v;
    else plan_hi = v;
  endtask

  task automatic set_band(logic [15:0] lo, logic [15:0] hi);
    add_settle();
    add_write(REG_LOW, lo);
    add_write(REG_HIGH, hi);
  endtask

  // Mostly samples inside the current band, some on its edges, the rest
  // anywhere in the full range.
  task automatic add_random_sample();
    int          pick;
    logic [15:0] v;
    pick = $urandom_range(0, 9);
    if (pick <= 6 && plan_lo <= plan_hi) begin
      v = plan_lo + 16'($urandom_range(0, plan_hi - plan_lo));
    end else if (pick == 7) begin
      case ($urandom_range(0, 3))
        0:       v = plan_lo - 16'd1;
        1:       v = plan_lo;
        2:       v = plan_hi;
        default: v = plan_hi + 16'd1;
      endcase
    end else begin
      v = 16'($urandom_range(0, 65535));
    end
    add_sample(v);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence and end of run
  // ---------------------------------------------------------------------
  initial begin
    int          n;
    logic [15:0] lo;
    logic [15:0] hi;

    // Reset band 0..65535: quarter width 16383, covering each segment, the
    // joins between them and the top where green overshoots and saturates.
    add_sample(16'd0);
    add_sample(16'd1);
    add_sample(16'd16383);
    add_sample(16'd32766);
    add_sample(16'd49148);
    add_sample(16'd49149);
    add_sample(16'd57000);
    add_sample(16'd65532);
    add_sample(16'd65535);
    // Band of zero width, with samples on either side.
    set_band(16'd1000, 16'd1000);
    add_sample(16'd999);
    add_sample(16'd1000);
    add_sample(16'd1001);
    // Band too narrow for a gradient.
    set_band(16'd100, 16'd103);
    add_sample(16'd99);
    add_sample(16'd100);
    add_sample(16'd103);
    add_sample(16'd104);
    // Low above high: every sample is either above or below the band.
    set_band(16'd500, 16'd200);
    add_sample(16'd300);
    add_sample(16'd0);
    add_sample(16'd65535);
    // Smallest band that still has a gradient.
    set_band(16'd0, 16'd4);
    add_sample(16'd0);
    add_sample(16'd2);
    add_sample(16'd3);
    add_sample(16'd4);
    // Both levels at the very top.
    set_band(16'hFFFF, 16'hFFFF);
    add_sample(16'hFFFF);
    add_sample(16'h0000);

    for (int ph = 0; ph < 16; ph++) begin
      case ($urandom_range(0, 5))
        0: set_band(16'h0000, 16'hFFFF);
        1: begin
          lo = 16'($urandom_range(0, 65535));
          hi = 16'($urandom_range(lo, 65535));
          set_band(lo, hi);
        end
        2: begin
          lo = 16'($urandom_range(0, 65528));
          set_band(lo, lo + 16'($urandom_range(0, 7)));
        end
        3: begin
          hi = 16'($urandom_range(0, 65534));
          set_band(16'($urandom_range(hi + 1, 65535)), hi);
        end
        4: begin
          // Move only one level and keep the other from the previous phase.
          add_settle();
          if ($urandom_range(0, 1) == 0) add_write(REG_LOW, 16'($urandom_range(0, plan_hi)));
          else add_write(REG_HIGH, 16'($urandom_range(plan_lo, 65535)));
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       set_band(16'h0000, 16'h0000);
            1:       set_band(16'hFFFF, 16'h0000);
            default: set_band(16'h0000, 16'hFFFF);
          endcase
        end
      endcase
      n = $urandom_range(20, 36);
      for (int k = 0; k < n; k++) begin
        // Now and then the sender holds back until the pipeline is empty.
        if ($urandom_range(0, 39) == 0) add_settle();
        add_random_sample();
      end
    end

    while (!rst_ni) @(posedge clk_i);
    // Checked on the falling edge, once the driver and monitor have settled.
    @(negedge clk_i);
    while (job_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0) @(negedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("[luminance_false_color_map] OK");
    end else begin
      $display("[luminance_false_color_map] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sample driver: works through job_q, colouring each accepted sample.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic               v_nxt;
    logic [SampleW-1:0] d_nxt;
    logic               we_nxt;
    cfg_reg_e           sel_nxt;
    logic [LvlW-1:0]    w_nxt;
    job_t               cur;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      cfg_we_i      <= 1'b0;
      cfg_idx_i     <= REG_LOW;
      cfg_data_i    <= '0;
      band_lo = LowLevelRst;
      band_hi = HighLevelRst;
      tx_wait = 0;
      tx_calm = 0;
    end else begin
      v_nxt   = s_axis_tvalid;
      d_nxt   = s_axis_tdata;
      we_nxt  = 1'b0;
      sel_nxt = cfg_idx_i;
      w_nxt   = cfg_data_i;
      if (tx_fire) begin
        pixel_q.push_back(false_colour(s_axis_tdata[15:0], band_lo, band_hi));
        v_nxt = 1'b0;
        // Gap before the next sample; occasionally a run with no gaps at all.
        if (tx_calm != 0) begin
          tx_calm--;
          tx_wait = 0;
        end else begin
          tx_wait = $urandom_range(0, MaxGap);
          if ($urandom_range(0, 15) == 0) tx_calm = $urandom_range(20, 60);
        end
      end
      if (!v_nxt) begin
        if (tx_wait != 0) begin
          tx_wait--;
        end else if (job_q.size() != 0) begin
          cur = job_q[0];
          case (cur.act)
            ACT_SAMPLE: begin
              cur   = job_q.pop_front();
              v_nxt = 1'b1;
              d_nxt = cur.value;
            end
            ACT_WRITE: begin
              cur     = job_q.pop_front();
              we_nxt  = 1'b1;
              sel_nxt = cur.sel;
              w_nxt   = cur.value;
              if (cur.sel == REG_LOW) band_lo = cur.value;
              else band_hi = cur.value;
            end
            default: begin
              if (pixel_q.size() == 0) cur = job_q.pop_front();
            end
          endcase
        end
      end
      s_axis_tvalid <= v_nxt;
      s_axis_tdata  <= d_nxt;
      cfg_we_i      <= we_nxt;
      cfg_idx_i     <= sel_nxt;
      cfg_data_i    <= w_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Pixel monitor: random back-pressure and in-order comparison.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic   rdy_nxt;
    pixel_t want;
    pixel_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
      rx_calm = 0;
    end else begin
      rdy_nxt = m_axis_tready;
      if (rx_fire) begin
        got = pixel_t'(m_axis_tdata);
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: pixel (%0d,%0d,%0d) arrived with no sample outstanding",
                   $time, got.red, got.green, got.blue);
        end else begin
          want = pixel_q.pop_front();
          if (got.red != want.red || got.green != want.green || got.blue != want.blue) begin
            errors++;
            $display("%0t: pixel mismatch, expected rgb (%0d,%0d,%0d), got (%0d,%0d,%0d)",
                     $time, want.red, want.green, want.blue, got.red, got.green, got.blue);
          end
        end
        if (rx_calm != 0) begin
          rx_calm--;
          rx_wait = 0;
        end else begin
          rx_wait = $urandom_range(0, MaxGap);
          if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(20, 60);
        end
        rdy_nxt = (rx_wait == 0);
      end else if (!m_axis_tready) begin
        if (rx_wait != 0) rx_wait--;
        if (rx_wait == 0) rdy_nxt = 1'b1;
      end
      m_axis_tready <= rdy_nxt;
    end
  end

  // Ends the run if neither side completes a transfer for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || tx_fire || rx_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("[luminance_false_color_map] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
